FILE: rtl/core/smwd_pkg.sv
// shared types, constants and helpers for the stable weight mode detector
`default_nettype none

package smwd_pkg;

   // field widths fixed by the sample format
   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned TOL_W    = 16;
   localparam int unsigned DIFF_W   = SAMPLE_W + 1;

   // defaults and reset values
   localparam int unsigned BATCH_SIZE_DEF = 10;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd10;
   localparam logic signed [SAMPLE_W-1:0] LAST_RESET = -32'sd100000;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PIV,
      ST_PIVW,
      ST_CMP,
      ST_DECIDE,
      ST_OUT
   } state_type;

   // result handed from the controller to the output register
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] weight;
      logic                       empty;
   } res_type;

   // exact magnitude of a - b at one extra bit
   function automatic logic [DIFF_W-1:0] abs_diff(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b
   );
      logic [DIFF_W-1:0] d;
      d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
      return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/smwd_if.sv
// valid/ready channel interfaces for samples and reports
`default_nettype none

interface smwd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [smwd_pkg::SAMPLE_W-1:0] weight_sample;

   modport source (output valid, output weight_sample, input ready);
   modport sink   (input valid, input weight_sample, output ready);
endinterface

interface smwd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [smwd_pkg::SAMPLE_W-1:0] reported_weight;
   logic                                 scale_empty;

   modport source (output valid, output reported_weight, output scale_empty, input ready);
   modport sink   (input valid, input reported_weight, input scale_empty, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/stable_weight_mode_detector.sv
// top level: stable weight reporting from load-cell samples
//
//  channel   dir  handshake      payload
//  req_ch    in   valid/ready    weight_sample      (s32, value x 100000)
//  rsp_ch    out  valid/ready    reported_weight    (s32), scale_empty (1)
//  csr_*     in   wr_en only     csr_wr_data        (u16 match tolerance)
//
// a nonzero sample that does not fill the batch, or a zero that does not report, leaves
// the block idle and ready for the next sample; a zero that reports waits for the output
// register to take it. the sample that fills the batch starts a scan with one store read
// per cycle through the one read port; no new sample is taken until the scan has finished.
// reset is synchronous; the tolerance returns to 10 and the last report to -1.0.
// one beat held in the output register does not block intake; a second result holds
// the input off until the output register frees up.
`default_nettype none

module stable_weight_mode_detector #(
   parameter int unsigned BATCH_SIZE = smwd_pkg::BATCH_SIZE_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   smwd_req_if.sink                            req_ch,
   smwd_rsp_if.source                          rsp_ch,
   input  wire logic                           csr_wr_en,
   input  wire logic [smwd_pkg::TOL_W-1:0]     csr_wr_data
);

   localparam int unsigned AW = $clog2(BATCH_SIZE);

   logic [smwd_pkg::TOL_W-1:0]           tol_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [smwd_pkg::SAMPLE_W-1:0] rsp_weight_ff, rsp_weight_in;
   logic                                 rsp_empty_ff, rsp_empty_in;
   logic                                 rsp_free;
   smwd_pkg::res_type                    res;
   logic                                 mem_we;
   logic [AW-1:0]                        mem_waddr;
   logic signed [smwd_pkg::SAMPLE_W-1:0] mem_wdata;
   logic [AW-1:0]                        mem_raddr;
   logic signed [smwd_pkg::SAMPLE_W-1:0] mem_rdata;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= smwd_pkg::TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // output register, refilled as the held beat leaves
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (rsp_free) begin
         rsp_valid_in  = res.valid;
         rsp_weight_in = res.weight;
         rsp_empty_in  = res.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_weight_ff <= rsp_weight_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.reported_weight = rsp_weight_ff;
   assign rsp_ch.scale_empty     = rsp_empty_ff;

   // sample store
   smwd_sample_mem #(
      .DEPTH (BATCH_SIZE)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // batch and scan control
   smwd_ctrl #(
      .BATCH_SIZE (BATCH_SIZE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_sample (req_ch.weight_sample),
      .tol        (tol_ff),
      .rsp_free   (rsp_free),
      .res        (res),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

endmodule

`default_nettype wire

FILE: rtl/core/smwd_sample_mem.sv
// sample store: one write port, one read port, registered read data
`default_nettype none

module smwd_sample_mem #(
   parameter int unsigned DEPTH = smwd_pkg::BATCH_SIZE_DEF,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  wire logic                                 clock,
   input  wire logic                                 we,
   input  wire logic [AW-1:0]                        waddr,
   input  wire logic signed [smwd_pkg::SAMPLE_W-1:0] wdata,
   input  wire logic [AW-1:0]                        raddr,
   output      logic signed [smwd_pkg::SAMPLE_W-1:0] rdata
);

   logic signed [smwd_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic signed [smwd_pkg::SAMPLE_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, read data registered
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: rtl/core/smwd_ctrl.sv
// batch gathering, pairwise mode scan over the store, and report decision
`default_nettype none

module smwd_ctrl #(
   parameter int unsigned BATCH_SIZE = smwd_pkg::BATCH_SIZE_DEF,
   localparam int unsigned AW        = $clog2(BATCH_SIZE),
   localparam int unsigned CW        = $clog2(BATCH_SIZE + 1)
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic signed [smwd_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic [smwd_pkg::TOL_W-1:0]           tol,
   input  wire logic                                 rsp_free,
   output      smwd_pkg::res_type                    res,
   output      logic                                 mem_we,
   output      logic [AW-1:0]                        mem_waddr,
   output      logic signed [smwd_pkg::SAMPLE_W-1:0] mem_wdata,
   output      logic [AW-1:0]                        mem_raddr,
   input  wire logic signed [smwd_pkg::SAMPLE_W-1:0] mem_rdata
);

   localparam logic [AW-1:0] LAST_IDX = AW'(BATCH_SIZE - 1);
   localparam logic [AW-1:0] LAST_PIV = AW'(BATCH_SIZE - 2);

   smwd_pkg::state_type state_ff, state_in;
   logic [AW-1:0] held_ff, held_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] j_ff, j_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] best_cnt_ff, best_cnt_in;
   logic signed [smwd_pkg::SAMPLE_W-1:0] pivot_ff, pivot_in;
   logic signed [smwd_pkg::SAMPLE_W-1:0] best_ff, best_in;
   logic signed [smwd_pkg::SAMPLE_W-1:0] last_ff, last_in;
   logic signed [smwd_pkg::SAMPLE_W-1:0] res_weight_ff, res_weight_in;
   logic res_empty_ff, res_empty_in;

   logic                            accept;
   logic                            match;
   logic [CW-1:0]                   cnt_sum;
   logic [smwd_pkg::DIFF_W-1:0]     tol_ext;

   assign tol_ext = smwd_pkg::DIFF_W'(tol);
   assign accept  = req_valid && req_ready;

   // pairwise compare of the pivot against the entry just read
   assign match   = smwd_pkg::abs_diff(pivot_ff, mem_rdata) < tol_ext;
   assign cnt_sum = cnt_ff + CW'(match);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= smwd_pkg::ST_IDLE;
         held_ff     <= '0;
         last_ff     <= smwd_pkg::LAST_RESET;
      end else begin
         state_ff    <= state_in;
         held_ff     <= held_in;
         last_ff     <= last_in;
      end
   end

   // scan datapath registers
   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      cnt_ff        <= cnt_in;
      best_cnt_ff   <= best_cnt_in;
      pivot_ff      <= pivot_in;
      best_ff       <= best_in;
      res_weight_ff <= res_weight_in;
      res_empty_ff  <= res_empty_in;
   end

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      last_in       = last_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      cnt_in        = cnt_ff;
      best_cnt_in   = best_cnt_ff;
      pivot_in      = pivot_ff;
      best_in       = best_ff;
      res_weight_in = res_weight_ff;
      res_empty_in  = res_empty_ff;
      req_ready     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = held_ff;
      mem_wdata     = req_sample;
      mem_raddr     = i_ff;
      res.valid     = 1'b0;
      res.weight    = res_weight_ff;
      res.empty     = res_empty_ff;

      case (state_ff)
         smwd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (req_sample == '0) begin
                  // zero clears the batch, reports once
                  held_in = '0;
                  if (last_ff != '0) begin
                     last_in       = '0;
                     res_weight_in = '0;
                     res_empty_in  = 1'b1;
                     state_in      = smwd_pkg::ST_OUT;
                  end
               end else begin
                  mem_we = 1'b1;
                  if (held_ff == LAST_IDX) begin
                     held_in     = '0;
                     i_in        = '0;
                     best_cnt_in = '0;
                     state_in    = smwd_pkg::ST_PIV;
                  end else begin
                     held_in = held_ff + AW'(1);
                  end
               end
            end
         end
         smwd_pkg::ST_PIV: begin
            // read of the first pivot issued at i
            state_in = smwd_pkg::ST_PIVW;
         end
         smwd_pkg::ST_PIVW: begin
            pivot_in  = mem_rdata;
            cnt_in    = CW'(1);
            j_in      = i_ff + AW'(1);
            mem_raddr = i_ff + AW'(1);
            state_in  = smwd_pkg::ST_CMP;
         end
         smwd_pkg::ST_CMP: begin
            if (j_ff != LAST_IDX) begin
               cnt_in    = cnt_sum;
               j_in      = j_ff + AW'(1);
               mem_raddr = j_ff + AW'(1);
            end else begin
               // pivot done: keep the first strictly greatest count
               if (cnt_sum > best_cnt_ff) begin
                  best_cnt_in = cnt_sum;
                  best_in     = pivot_ff;
               end
               i_in      = i_ff + AW'(1);
               mem_raddr = i_ff + AW'(1);
               state_in  = (i_ff == LAST_PIV) ? smwd_pkg::ST_DECIDE : smwd_pkg::ST_PIVW;
            end
         end
         smwd_pkg::ST_DECIDE: begin
            // the last sample alone can never beat the first, so it is skipped
            if (smwd_pkg::abs_diff(best_ff, last_ff) > tol_ext) begin
               last_in       = best_ff;
               res_weight_in = best_ff;
               res_empty_in  = 1'b0;
               state_in      = smwd_pkg::ST_OUT;
            end else begin
               state_in = smwd_pkg::ST_IDLE;
            end
         end
         smwd_pkg::ST_OUT: begin
            res.valid = 1'b1;
            if (rsp_free) begin
               state_in = smwd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smwd_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   // fill count never reaches the batch size
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= LAST_IDX)
      else $error("fill count out of range");

   // a zero sample always empties the batch
   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_sample == '0) |=> held_ff == '0)
      else $error("zero sample did not clear batch");

   // a pending result always matches the last reported value
   a_res_last: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> last_ff == res_weight_ff)
      else $error("pending result differs from last reported");

   // compare index stays ahead of the pivot
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == smwd_pkg::ST_CMP |-> j_ff > i_ff)
      else $error("scan index not past pivot");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// self-checking bench for the stable weight mode detector: batches, zeros, tolerance, stalls
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned SAMPLE_W      = smwd_pkg::SAMPLE_W;
   localparam int unsigned TOL_W         = smwd_pkg::TOL_W;
   localparam int unsigned BATCH         = smwd_pkg::BATCH_SIZE_DEF;
   // one full scan of the store plus a little margin
   localparam int unsigned SETTLE_CYCLES = BATCH * (BATCH - 1) / 2 + BATCH + 3 + 8;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned IDLE_LIMIT    = 2000;
   localparam int unsigned PHASE_ITEMS   = 200;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] weight;
      logic                       empty;
   } report_type;

   logic clock = 1'b0;
   logic reset;
   logic             csr_wr_en;
   logic [TOL_W-1:0] csr_wr_data;

   smwd_req_if req_ch();
   smwd_rsp_if rsp_ch();

   stable_weight_mode_detector #(.BATCH_SIZE(BATCH)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // bench copy of the detector state
   logic [TOL_W-1:0]           model_tol;
   logic signed [SAMPLE_W-1:0] model_store [BATCH];
   int unsigned                model_held;
   logic signed [SAMPLE_W-1:0] model_last;

   report_type  pending_reports [$];
   int unsigned report_errors = 0;
   int unsigned samples_sent  = 0;
   int unsigned burst_left    = 0;
   bit          steady_sender = 1'b0;
   int unsigned hold_request  = 0;
   int unsigned idle_cycles   = 0;

   // exact distance between two samples, no wrap
   function automatic longint unsigned weight_gap(input logic signed [SAMPLE_W-1:0] a,
                                                  input logic signed [SAMPLE_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return (d < 0) ? longint'(-d) : d;
   endfunction

   // update the bench state for one accepted sample and queue any report it causes
   function automatic void predict_report(input logic signed [SAMPLE_W-1:0] w);
      report_type                 r;
      logic signed [SAMPLE_W-1:0] winner;
      int unsigned                best, hits;
      if (w == 0) begin
         model_held = 0;
         if (model_last != 0) begin
            model_last = 0;
            r.weight   = '0;
            r.empty    = 1'b1;
            pending_reports.push_back(r);
         end
         return;
      end
      if (model_held < BATCH) begin
         model_store[model_held] = w;
         model_held++;
      end
      if (model_held >= BATCH) begin
         best   = 0;
         winner = model_store[0];
         // first sample with the strictly largest count of near matches after it
         for (int i = 0; i < BATCH; i++) begin
            hits = 1;
            for (int j = i + 1; j < BATCH; j++)
               if (weight_gap(model_store[i], model_store[j]) < model_tol) hits++;
            if (hits > best) begin
               best   = hits;
               winner = model_store[i];
            end
         end
         model_held = 0;
         if (weight_gap(winner, model_last) > model_tol) begin
            model_last = winner;
            r.weight   = winner;
            r.empty    = 1'b0;
            pending_reports.push_back(r);
         end
      end
   endfunction

   // offer one sample, wait for its beat, then maybe take a gap between bursts
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] w);
      int unsigned gap;
      req_ch.valid         <= 1'b1;
      req_ch.weight_sample <= w;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      predict_report(w);
      samples_sent++;
      if (!steady_sender) begin
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 5);
            if (gap != 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   // sender pauses until every queued report has come out
   task automatic wait_for_reports();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // tolerance write, only once the block has gone quiet
   task automatic set_tolerance(input logic [TOL_W-1:0] value);
      wait_for_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_tol = value;
   endtask

   // samples scattered around a center, zero replaced so the batch stays intact
   task automatic send_cluster(input logic signed [SAMPLE_W-1:0] center,
                               input int unsigned spread, input int unsigned count);
      logic signed [SAMPLE_W-1:0] w;
      int                         offset;
      for (int k = 0; k < count; k++) begin
         offset = int'($urandom_range(0, 2 * spread)) - int'(spread);
         w = center + offset;
         if (w == 0) w = 1;
         send_sample(w);
      end
   endtask

   // samples sitting right on the match boundary around a center
   task automatic send_edge_cluster(input logic signed [SAMPLE_W-1:0] center);
      logic signed [SAMPLE_W-1:0] w;
      int                         t;
      t = int'(model_tol);
      for (int k = 0; k < BATCH; k++) begin
         case ($urandom_range(0, 4))
            0:       w = center;
            1:       w = center + t - 1;
            2:       w = center + t;
            3:       w = center - t + 1;
            default: w = center - t;
         endcase
         if (w == 0) w = 1;
         send_sample(w);
      end
   endtask

   // mostly whole batches with random content, some noise and cut-short batches
   task automatic run_random_batches(input int unsigned count);
      int unsigned                goal, pick, spread;
      logic signed [SAMPLE_W-1:0] center;
      goal = samples_sent + count;
      while (samples_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            send_sample($urandom);
         end else if (pick < 10) begin
            send_sample('0);
         end else if (pick < 18) begin
            send_cluster($urandom, $urandom_range(0, 100), $urandom_range(1, BATCH - 1));
            send_sample('0);
         end else if (pick < 22) begin
            wait_for_reports();
         end else begin
            case ($urandom_range(0, 4))
               0:       center = $urandom;
               1:       center = int'($urandom_range(0, 20000000)) - 10000000;
               2:       center = model_last;
               3:       center = model_last + int'(model_tol) + int'($urandom_range(0, 1));
               default: center = model_last - int'(model_tol) - int'($urandom_range(0, 1));
            endcase
            if ($urandom_range(0, 3) == 0) begin
               send_edge_cluster(center);
            end else begin
               spread = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3 * model_tol + 2);
               send_cluster(center, spread, BATCH);
            end
         end
      end
   endtask

   // zero reports once, repeats stay quiet, a zero drops a partial batch
   task automatic test_empty_scale();
      send_sample('0);
      send_sample('0);
      send_sample(32'sd5);
      send_sample(-32'sd7);
      send_sample('0);
   endtask

   // full-scale values, both signs, near and just outside the tolerance
   task automatic test_sample_extremes();
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sh8000_0000);
      send_sample(32'sh8000_0000);
      send_sample(32'sh7FFF_FFFF);
      send_sample(32'sh8000_0001);
      send_sample(32'sd1);
      send_sample(-32'sd1);
      send_sample(32'sh7FFF_FFF6);
      send_sample(32'sh7FFF_FFF5);
      send_sample(32'sh8000_0000);
   endtask

   // a batch whose mode matches the last report gives nothing
   task automatic test_mode_unchanged();
      send_cluster(model_last, 0, BATCH);
   endtask

   // random traffic under several tolerance settings, extremes included
   task automatic test_tolerance_sweep();
      set_tolerance('0);
      run_random_batches(PHASE_ITEMS);
      set_tolerance('1);
      run_random_batches(PHASE_ITEMS);
      set_tolerance(16'hFFFF);
      run_random_batches(PHASE_ITEMS);
      set_tolerance(16'd1);
      run_random_batches(PHASE_ITEMS);
      set_tolerance(TOL_W'($urandom));
      run_random_batches(PHASE_ITEMS);
      set_tolerance(16'd10);
      run_random_batches(PHASE_ITEMS);
   endtask

   // receiver holds off while far-apart batches pile up reports
   task automatic test_output_stall();
      wait_for_reports();
      hold_request  = HOLD_CYCLES;
      steady_sender = 1'b1;
      for (int k = 0; k < 5; k++)
         send_cluster(-32'sd1500000000 + k * 32'sd700000000, 50, BATCH);
      steady_sender = 1'b0;
      wait_for_reports();
   endtask

   initial begin
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.weight_sample <= '0;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= '0;
      model_tol  = 16'd10;
      model_held = 0;
      model_last = -32'sd100000;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_scale();
      test_sample_extremes();
      test_mode_unchanged();
      test_tolerance_sweep();
      test_output_stall();

      wait_for_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (report_errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   // receiver: ready pattern switches between random styles, long hold on request
   initial begin : receiver
      int unsigned style, style_left, hold_left;
      style      = 0;
      style_left = 0;
      hold_left  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style      = $urandom_range(0, 3);
               style_left = $urandom_range(8, 80);
            end
            style_left--;
            case (style)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= $urandom_range(0, 1);
               2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ch.ready <= style_left[2];
            endcase
         end
      end
   end

   // compare each report beat with the oldest expected one
   always @(posedge clock) begin : report_check
      report_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_reports.size() == 0) begin
            report_errors++;
            if (report_errors <= 10)
               $display("unexpected report: weight %0d empty %0b",
                        rsp_ch.reported_weight, rsp_ch.scale_empty);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_ch.reported_weight !== want.weight ||
                rsp_ch.scale_empty !== want.empty) begin
               report_errors++;
               if (report_errors <= 10)
                  $display("report mismatch: expected %0d/%0b, got %0d/%0b",
                           want.weight, want.empty, rsp_ch.reported_weight,
                           rsp_ch.scale_empty);
            end
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

endmodule

FILE: filelist.f
rtl/core/smwd_pkg.sv
rtl/core/smwd_if.sv
rtl/core/smwd_sample_mem.sv
rtl/core/smwd_ctrl.sv
rtl/core/stable_weight_mode_detector.sv
bench/tb_top.sv
